@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; compiled out with
// NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

@@ src/mkte_pkg.sv @@
// ----------------------------------------------------------------------------
// mkte_pkg
// Types, key tables and constants for the matrix keyboard text entry block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mkte_pkg;

  localparam int unsigned MATRIX_KEYS = 35;

  localparam logic [15:0] REPEAT_MS_RESET  = 16'd400;
  localparam logic [7:0]  TEXT_LIMIT_RESET = 8'd80;

  localparam logic [6:0] CH_NONE     = 7'h00;
  localparam logic [6:0] CH_BKSP     = 7'h08;
  localparam logic [6:0] CH_SPACE    = 7'h20;
  localparam logic [6:0] CH_DOLLAR   = 7'h24;
  localparam logic [6:0] CH_TILDE    = 7'h7E;
  localparam logic [6:0] CASE_OFFSET = 7'd32;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_INSERT = 2'd1,
    EV_ERASE  = 2'd2,
    EV_DONE   = 2'd3
  } event_e;

  typedef enum logic {
    CFG_REPEAT_MS  = 1'b0,
    CFG_TEXT_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KK_CHAR  = 3'd0,
    KK_SYM   = 3'd1,
    KK_ALT   = 3'd2,
    KK_SHL   = 3'd3,
    KK_SHR   = 3'd4,
    KK_ENTER = 3'd5,
    KK_BKSP  = 3'd6
  } key_kind_e;

  typedef struct packed {
    logic [MATRIX_KEYS-1:0] key_matrix;
    logic                   center_pressed;
    logic [9:0]             elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [6:0] char_code;
    logic [7:0] position;
    logic       buffer_full;
    logic       lock_on;
  } out_item_t;

  // Decoded scan: winning character key plus modifier flags.
  typedef struct packed {
    logic [6:0] chr;
    logic [6:0] symb;
    logic       sym;
    logic       shl;
    logic       shr;
    logic       enter;
  } key_dec_t;

  // Index is column*7+row.
  localparam key_kind_e KEY_KIND [MATRIX_KEYS] = '{
    KK_CHAR, KK_CHAR, KK_SYM,  KK_CHAR, KK_ALT,   KK_CHAR, KK_CHAR,
    KK_CHAR, KK_CHAR, KK_CHAR, KK_CHAR, KK_CHAR,  KK_CHAR, KK_SHL,
    KK_CHAR, KK_CHAR, KK_CHAR, KK_SHR,  KK_CHAR,  KK_CHAR, KK_CHAR,
    KK_CHAR, KK_CHAR, KK_CHAR, KK_ENTER, KK_CHAR, KK_CHAR, KK_CHAR,
    KK_CHAR, KK_CHAR, KK_CHAR, KK_BKSP, KK_CHAR,  KK_CHAR, KK_CHAR
  };

  // Upper case letters and fixed characters.
  localparam logic [6:0] KEY_CHAR [MATRIX_KEYS] = '{
    7'h51, 7'h57, 7'h00, 7'h41, 7'h00, 7'h20, 7'h7E,
    7'h45, 7'h53, 7'h44, 7'h50, 7'h58, 7'h5A, 7'h00,
    7'h52, 7'h47, 7'h54, 7'h00, 7'h56, 7'h43, 7'h46,
    7'h55, 7'h48, 7'h59, 7'h00, 7'h42, 7'h4E, 7'h4A,
    7'h4F, 7'h4C, 7'h49, 7'h08, 7'h24, 7'h4D, 7'h4B
  };

  // Symbol layer.
  localparam logic [6:0] KEY_SYMBOL [MATRIX_KEYS] = '{
    7'h23, 7'h31, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h30,
    7'h32, 7'h34, 7'h35, 7'h40, 7'h38, 7'h37, 7'h00,
    7'h33, 7'h2F, 7'h28, 7'h00, 7'h3F, 7'h39, 7'h36,
    7'h5F, 7'h3A, 7'h29, 7'h00, 7'h21, 7'h2C, 7'h3B,
    7'h2B, 7'h22, 7'h2D, 7'h00, 7'h60, 7'h2E, 7'h27
  };

endpackage

@@ src/matrix_keyboard_text_entry.sv @@
// Path: an accepted scan is held in the input register, then is decoded and applied to the
//   entry state as it loads the result register, which takes it only when it is free.
// Throughput: one scan per cycle while out_ready_i does not stall; the state update in the decode stage sets it.
// Stall: out_ready_i low holds the result register and backs up into the input register.
// Reset: rst_ni low clears all entry state and empties both stages; repeat_ms returns to
//   400 and text_limit to 80.
// ----------------------------------------------------------------------------
// matrix_keyboard_text_entry
// Turns key matrix scans into insert / erase / done edit events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module matrix_keyboard_text_entry
  import mkte_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  // scan channel
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_i,
  // event channel
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_o,
  // register write channel
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] repeat_ms_q;
  logic [7:0]  text_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_ms_q  <= REPEAT_MS_RESET;
      text_limit_q <= TEXT_LIMIT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_REPEAT_MS:  repeat_ms_q  <= cfg_data_i;
        CFG_TEXT_LIMIT: text_limit_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake: input register feeds the update stage, which loads
  // the result register. A stage advances whenever the one after it is free.
  // --------------------------------------------------------------------------
  in_item_t  in_q;
  logic      s1_valid_q;
  logic      s1_fire;
  out_item_t out_q, res;
  logic      out_valid_q;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
  end

  // --------------------------------------------------------------------------
  // Scan decode
  // --------------------------------------------------------------------------
  key_dec_t dec;

  mkte_key_decode u_key_decode (
    .keys_i (in_q.key_matrix),
    .dec_o  (dec)
  );

  // --------------------------------------------------------------------------
  // Entry state
  // --------------------------------------------------------------------------
  logic [7:0]  write_pos_q, write_pos_d;
  logic        full_q, full_d;
  logic [6:0]  prev_key_q, prev_key_d;
  logic        lock_q, lock_d;
  logic        toggled_q, toggled_d;
  logic [15:0] since_q, since_d;
  logic        done_pend_q, done_pend_d;

  logic [16:0] since_sum;
  logic [15:0] since_sat;
  logic [7:0]  wp_inc;
  logic [6:0]  ins_code;
  logic        upper;

  assign since_sum = {1'b0, since_q} + 17'(in_q.elapsed_ms);
  assign since_sat = since_sum[16] ? 16'hFFFF : since_sum[15:0];
  assign wp_inc    = write_pos_q + 8'd1;

  // case selection: symbol layer, else upper case, else lower case (+32)
  assign upper = dec.shl || dec.shr || lock_q || (dec.chr == CH_DOLLAR) ||
                 (dec.chr == CH_SPACE) || (dec.chr == CH_TILDE);

  always_comb begin
    if (dec.sym) begin
      ins_code = dec.symb;
    end else if (upper) begin
      ins_code = dec.chr;
    end else begin
      ins_code = dec.chr + CASE_OFFSET;
    end
  end

  always_comb begin
    write_pos_d = write_pos_q;
    full_d      = full_q;
    prev_key_d  = prev_key_q;
    lock_d      = lock_q;
    toggled_d   = toggled_q;
    since_d     = since_q;
    done_pend_d = done_pend_q;
    res         = '{event_kind: EV_NONE, char_code: CH_NONE, position: write_pos_q,
                    buffer_full: full_q, lock_on: lock_q};

    if (s1_fire) begin
      if (in_q.center_pressed || done_pend_q) begin
        // finish without decoding this scan
        res.event_kind = EV_DONE;
        write_pos_d = '0;
        full_d      = 1'b0;
        prev_key_d  = CH_NONE;
        lock_d      = 1'b0;
        toggled_d   = 1'b0;
        since_d     = '0;
        done_pend_d = 1'b0;
      end else begin
        since_d = since_sat;

        if (dec.chr != prev_key_q) begin
          if (dec.chr == CH_BKSP) begin
            if (write_pos_q != '0) begin
              write_pos_d    = write_pos_q - 8'd1;
              full_d         = 1'b0;
              since_d        = '0;
              res.event_kind = EV_ERASE;
              res.position   = write_pos_q - 8'd1;
            end
          end else if (!full_q && dec.chr != CH_NONE) begin
            write_pos_d    = wp_inc;
            if (wp_inc >= text_limit_q) begin
              full_d = 1'b1;
            end
            since_d        = '0;
            res.event_kind = EV_INSERT;
            res.char_code  = ins_code;
          end
        end

        // shift lock toggles once per press of both shifts
        if (dec.shl && dec.shr && !toggled_q) begin
          lock_d    = !lock_q;
          toggled_d = 1'b1;
        end
        if (!dec.shl || !dec.shr) begin
          toggled_d = 1'b0;
        end

        // repeat timer: forget the key so a held key fires again
        prev_key_d = dec.chr;
        if (since_d > repeat_ms_q) begin
          prev_key_d = CH_SPACE;
          since_d    = '0;
        end

        res.buffer_full = full_d;
        res.lock_on     = lock_d;

        if (dec.enter) begin
          if (res.event_kind == EV_NONE) begin
            res.event_kind = EV_DONE;
            write_pos_d = '0;
            full_d      = 1'b0;
            prev_key_d  = CH_NONE;
            lock_d      = 1'b0;
            toggled_d   = 1'b0;
            since_d     = '0;
            done_pend_d = 1'b0;
          end else begin
            // report the edit now, done on the next transaction
            done_pend_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_pos_q <= '0;
      full_q      <= 1'b0;
      prev_key_q  <= CH_NONE;
      lock_q      <= 1'b0;
      toggled_q   <= 1'b0;
      since_q     <= '0;
      done_pend_q <= 1'b0;
    end else begin
      write_pos_q <= write_pos_d;
      full_q      <= full_d;
      prev_key_q  <= prev_key_d;
      lock_q      <= lock_d;
      toggled_q   <= toggled_d;
      since_q     <= since_d;
      done_pend_q <= done_pend_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // an erase always leaves the buffer not full
  `ASSERT_NEVER(a_erase_not_full, clk_i, rst_ni,
                out_valid_q && out_q.event_kind == EV_ERASE && out_q.buffer_full)
  // a pending done only follows an edit loaded in the same transaction
  `ASSERT_PROP(a_pend_after_edit, clk_i, rst_ni,
               $rose(done_pend_q) |-> out_valid_q &&
               (out_q.event_kind == EV_INSERT || out_q.event_kind == EV_ERASE))
  // done returns the entry state to its reset values
  `ASSERT_PROP(a_done_clears, clk_i, rst_ni,
               s1_fire && res.event_kind == EV_DONE |=>
               write_pos_q == '0 && !full_q && !lock_q && !done_pend_q)

endmodule

@@ src/mkte_key_decode.sv @@
// ----------------------------------------------------------------------------
// mkte_key_decode
// Scan decoder: last pressed character key in scan order, modifier flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mkte_key_decode
  import mkte_pkg::*;
(
  input  logic [MATRIX_KEYS-1:0] keys_i,
  output key_dec_t               dec_o
);

  always_comb begin
    dec_o = '0;
    // later keys overwrite earlier ones: last in scan order wins
    for (int unsigned i = 0; i < MATRIX_KEYS; i++) begin
      if (keys_i[i]) begin
        unique case (KEY_KIND[i])
          KK_CHAR: begin
            dec_o.chr  = KEY_CHAR[i];
            dec_o.symb = KEY_SYMBOL[i];
          end
          KK_SYM:   dec_o.sym   = 1'b1;
          KK_SHL:   dec_o.shl   = 1'b1;
          KK_SHR:   dec_o.shr   = 1'b1;
          KK_ENTER: dec_o.enter = 1'b1;
          KK_BKSP:  dec_o.chr   = CH_BKSP;
          default: ;
        endcase
      end
    end
  end

endmodule
